/* sv/trp_pkg.sv */
`default_nettype none

package trp_pkg;

    // One housekeeping sample as it arrives on the input channel.
    typedef struct packed {
        logic [15:0]        battery_millivolts;
        logic [15:0]        solar_current;
        logic [15:0]        system_current;
        logic [47:0]        low_rail_currents;
        logic [47:0]        high_rail_currents;
        logic [2:0]         battery_mode;
        logic [5:0]         switch_states;
        logic [63:0]        board_temps;
        logic signed [15:0] radio_temp;
    } t_sample;

    // One packed telemetry record.
    typedef struct packed {
        logic [7:0]        record_index;
        logic [7:0]        flag_byte;
        logic [7:0]        voltage_code;
        logic signed [7:0] net_current;
        logic [7:0]        low_rail_code;
        logic [7:0]        high_rail_code;
        logic signed [7:0] radio_temp_code;
        logic signed [7:0] board_temp_code;
        logic signed [7:0] battery_temp_code;
    } t_record;

    localparam logic [15:0] VOLT_OFFSET = 16'd4420;

    // Rail scaling: code = floor(sum * 255 / d), done as floor(sum * C / 2^30).
    // For 5500: 255/5500 = 51/1100, C = 51 * ceil(2^30 / 1100).
    // For 4500: 255/4500 = 17/300,  C = 17 * ceil(2^30 / 300).
    // Below the saturation limit the reciprocal error stays under one code.
    localparam int          RAIL_SHIFT     = 30;
    localparam logic [17:0] LOW_RAIL_SAT   = 18'd5522;
    localparam logic [25:0] LOW_RAIL_MULT  = 26'd49782579;
    localparam logic [17:0] HIGH_RAIL_SAT  = 18'd4518;
    localparam logic [25:0] HIGH_RAIL_MULT = 26'd60845380;

    localparam logic signed [17:0] S8_MAX = 18'sd127;
    localparam logic signed [17:0] S8_MIN = -18'sd127;

endpackage

`default_nettype wire

/* sv/trp_sample_if.sv */
`default_nettype none

interface trp_sample_if;
    import trp_pkg::*;

    logic    valid;
    logic    ready;
    t_sample data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/trp_record_if.sv */
`default_nettype none

interface trp_record_if;
    import trp_pkg::*;

    logic    valid;
    logic    ready;
    t_record data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/telemetry_record_packer.sv */
// A sample is held in the input register; its record then goes into the record register.
// Throughput: one word per cycle; the input register and the record register form a
// two-stage pipeline that advances whenever the record register is free or being taken.
// Reset (synchronous, active low) empties both stages and clears the record counter.
`default_nettype none

module telemetry_record_packer (
    input  wire           i_clk,
    input  wire           i_rst_n,
    trp_sample_if.sink    i_sample,
    trp_record_if.source  o_record
);
    import trp_pkg::*;

    logic       r_in_valid;
    t_sample    r_in_data;
    logic [7:0] r_in_index;
    logic [7:0] r_counter;
    logic       r_out_valid;
    t_record    r_out_data;

    logic       n_in_valid;
    logic       n_out_valid;
    logic [7:0] n_counter;
    logic       advance;
    logic       in_take;
    t_record    calc_record;

    trp_field_calc u_calc (
        .i_sample (r_in_data),
        .i_index  (r_in_index),
        .o_record (calc_record)
    );

    assign advance        = r_in_valid && (!r_out_valid || o_record.ready);
    assign i_sample.ready = !r_in_valid || advance;
    assign in_take        = i_sample.valid && i_sample.ready;

    always_comb begin
        n_in_valid  = in_take || (r_in_valid && !advance);
        n_out_valid = advance || (r_out_valid && !o_record.ready);
        n_counter   = in_take ? r_counter + 8'd1 : r_counter;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_counter   <= 8'd0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_counter   <= n_counter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data  <= i_sample.data;
            r_in_index <= r_counter;
        end
        if (advance) begin
            r_out_data <= calc_record;
        end
    end

    assign o_record.valid = r_out_valid;
    assign o_record.data  = r_out_data;

endmodule

`default_nettype wire

/* sv/trp_field_calc.sv */
`default_nettype none

module trp_field_calc (
    input  trp_pkg::t_sample i_sample,
    input  logic [7:0]       i_index,
    output trp_pkg::t_record o_record
);
    import trp_pkg::*;

    function automatic logic [7:0] clamp_s8(input logic signed [17:0] x);
        logic [7:0] res;
        if (x > S8_MAX) begin
            res = S8_MAX[7:0];
        end else if (x < S8_MIN) begin
            res = S8_MIN[7:0];
        end else begin
            res = x[7:0];
        end
        return res;
    endfunction

    function automatic logic [7:0] rail_code(input logic [47:0] cur_word,
                                             input logic [17:0] sat_lim,
                                             input logic [25:0] mult);
        logic [17:0] sum;
        logic [38:0] prod;
        logic [7:0]  res;
        sum  = 18'(cur_word[15:0]) + 18'(cur_word[31:16]) + 18'(cur_word[47:32]);
        prod = {26'd0, sum[12:0]} * {13'd0, mult};
        if (sum >= sat_lim) begin
            res = 8'hFF;
        end else begin
            res = prod[RAIL_SHIFT +: 8];
        end
        return res;
    endfunction

    logic [15:0]        volt_diff;
    logic [11:0]        volt_steps;
    logic [7:0]         volt_code;
    logic signed [17:0] net_sum;
    logic signed [15:0] t0, t1, t2, t3;
    logic signed [17:0] board_sum;
    logic signed [17:0] board_avg;
    logic signed [17:0] batt_sum;
    logic signed [17:0] batt_avg;
    logic [1:0]         mode_bits;

    always_comb begin
        volt_diff  = i_sample.battery_millivolts - VOLT_OFFSET;
        volt_steps = volt_diff[15:4];
        if (i_sample.battery_millivolts < VOLT_OFFSET) begin
            volt_code = 8'd0;
        end else if (volt_steps > 12'd255) begin
            volt_code = 8'hFF;
        end else begin
            volt_code = volt_steps[7:0];
        end
    end

    assign net_sum = signed'({2'b00, i_sample.solar_current})
                   - signed'({2'b00, i_sample.system_current});

    assign t0 = i_sample.board_temps[15:0];
    assign t1 = i_sample.board_temps[31:16];
    assign t2 = i_sample.board_temps[47:32];
    assign t3 = i_sample.board_temps[63:48];

    // Averages truncate toward zero, so negative sums get a bias before the shift.
    always_comb begin
        board_sum = 18'(t0) + 18'(t1) + 18'(t2) + 18'(t3);
        board_avg = (board_sum + (board_sum[17] ? 18'sd3 : 18'sd0)) >>> 2;
        batt_sum  = 18'(t0) + 18'(t1);
        batt_avg  = (batt_sum + (batt_sum[17] ? 18'sd1 : 18'sd0)) >>> 1;
    end

    assign mode_bits = i_sample.battery_mode[1:0] - 2'd1;

    always_comb begin
        o_record.record_index      = i_index;
        o_record.flag_byte         = {mode_bits, i_sample.switch_states};
        o_record.voltage_code      = volt_code;
        o_record.net_current       = clamp_s8(net_sum);
        o_record.low_rail_code     = rail_code(i_sample.low_rail_currents,
                                               LOW_RAIL_SAT, LOW_RAIL_MULT);
        o_record.high_rail_code    = rail_code(i_sample.high_rail_currents,
                                               HIGH_RAIL_SAT, HIGH_RAIL_MULT);
        o_record.radio_temp_code   = clamp_s8(18'(i_sample.radio_temp));
        o_record.board_temp_code   = clamp_s8(board_avg);
        o_record.battery_temp_code = clamp_s8(batt_avg);
    end

endmodule

`default_nettype wire

/* tb/tb_telemetry_record_packer.sv */
`default_nettype none

module tb_telemetry_record_packer;
    timeunit 1ns;
    timeprecision 1ps;

    import trp_pkg::*;

    localparam int RANDOM_SAMPLES = 1900;

    logic clk = 1'b0;
    logic rst_n;

    trp_sample_if smp_if ();
    trp_record_if rec_if ();

    telemetry_record_packer u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_sample (smp_if.sink),
        .o_record (rec_if.source)
    );

    t_sample    sample_backlog[$];
    t_record    pending_records[$];
    logic [7:0] record_seq = 8'd0;
    bit         sample_taken = 1'b0;
    int         n_sent = 0;
    int         n_checked = 0;
    int         n_errors = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [7:0] sat_s8(int x);
        if (x > 127) return 8'd127;
        if (x < -127) return 8'h81;
        return x[7:0];
    endfunction

    function automatic logic [7:0] rail_scale(logic [47:0] cur_word, int divisor);
        longint total;
        longint q;
        total = longint'(cur_word[15:0]) + longint'(cur_word[31:16]) + longint'(cur_word[47:32]);
        q = total * 255 / divisor;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // Expected record for one sample, given the running record number.
    function automatic t_record predict_record(t_sample s, logic [7:0] idx);
        t_record r;
        logic [2:0] mode_m1;
        int volt;
        int t0, t1, t2, t3;
        t0 = int'($signed(s.board_temps[15:0]));
        t1 = int'($signed(s.board_temps[31:16]));
        t2 = int'($signed(s.board_temps[47:32]));
        t3 = int'($signed(s.board_temps[63:48]));
        mode_m1 = s.battery_mode - 3'd1;
        if (s.battery_millivolts < VOLT_OFFSET) begin
            volt = 0;
        end else begin
            volt = (int'(s.battery_millivolts) - int'(VOLT_OFFSET)) / 16;
            if (volt > 255) volt = 255;
        end
        r.record_index      = idx;
        r.flag_byte         = {mode_m1[1:0], s.switch_states};
        r.voltage_code      = volt[7:0];
        r.net_current       = sat_s8(int'(s.solar_current) - int'(s.system_current));
        r.low_rail_code     = rail_scale(s.low_rail_currents, 5500);
        r.high_rail_code    = rail_scale(s.high_rail_currents, 4500);
        r.radio_temp_code   = sat_s8(int'(s.radio_temp));
        // Integer division in SystemVerilog truncates toward zero.
        r.board_temp_code   = sat_s8((t0 + t1 + t2 + t3) / 4);
        r.battery_temp_code = sat_s8((t0 + t1) / 2);
        return r;
    endfunction

    function automatic t_sample quiet_sample();
        t_sample s;
        s = '0;
        s.battery_mode = 3'd1;
        s.battery_millivolts = 16'd7000;
        return s;
    endfunction

    function automatic logic [15:0] near_zero16(int span);
        int v;
        v = int'($urandom_range(0, 2 * span)) - span;
        return v[15:0];
    endfunction

    function automatic t_sample random_sample();
        t_sample s;
        int k;
        s.battery_millivolts = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(4300, 8700));
        s.solar_current = 16'($urandom);
        if ($urandom_range(0, 2) == 0) begin
            s.system_current = 16'($urandom);
        end else begin
            k = int'(s.solar_current) + int'($urandom_range(0, 400)) - 200;
            if (k < 0) k = 0;
            if (k > 65535) k = 65535;
            s.system_current = k[15:0];
        end
        for (k = 0; k < 3; k++) begin
            s.low_rail_currents[16*k +: 16]  = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 2600));
            s.high_rail_currents[16*k +: 16] = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 2200));
        end
        s.battery_mode  = 3'($urandom);
        s.switch_states = 6'($urandom);
        for (k = 0; k < 4; k++) begin
            s.board_temps[16*k +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                         : near_zero16(300);
        end
        s.radio_temp = ($urandom_range(0, 2) == 0) ? 16'($urandom) : near_zero16(200);
        return s;
    endfunction

    task automatic check_byte(string fname, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %02h, actual %02h", $time, fname, want, got);
        end
    endtask

    // Sample side: a new word goes out only when the slot is empty or was just taken.
    always @(negedge clk) begin
        if (!rst_n) begin
            smp_if.valid <= 1'b0;
        end else if (!smp_if.valid || sample_taken) begin
            if (sample_backlog.size() != 0 &&
                ((n_sent >= 800 && n_sent < 1100) || $urandom_range(0, 99) >= 21)) begin
                smp_if.data  <= sample_backlog.pop_front();
                smp_if.valid <= 1'b1;
            end else begin
                smp_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        rec_if.ready <= rst_n &&
                        ((n_checked >= 800 && n_checked < 1100) || $urandom_range(0, 99) >= 21);
    end

    always @(posedge clk) begin
        t_record want;
        sample_taken <= rst_n && smp_if.valid && smp_if.ready;
        if (rst_n && rec_if.valid && rec_if.ready) begin
            if (pending_records.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected record word %h", $time, rec_if.data);
            end else begin
                want = pending_records.pop_front();
                check_byte("record_index", want.record_index, rec_if.data.record_index);
                check_byte("flag_byte", want.flag_byte, rec_if.data.flag_byte);
                check_byte("voltage_code", want.voltage_code, rec_if.data.voltage_code);
                check_byte("net_current", want.net_current, rec_if.data.net_current);
                check_byte("low_rail_code", want.low_rail_code, rec_if.data.low_rail_code);
                check_byte("high_rail_code", want.high_rail_code, rec_if.data.high_rail_code);
                check_byte("radio_temp_code", want.radio_temp_code,
                           rec_if.data.radio_temp_code);
                check_byte("board_temp_code", want.board_temp_code,
                           rec_if.data.board_temp_code);
                check_byte("battery_temp_code", want.battery_temp_code,
                           rec_if.data.battery_temp_code);
                n_checked++;
            end
        end
        if (rst_n && smp_if.valid && smp_if.ready) begin
            pending_records.push_back(predict_record(smp_if.data, record_seq));
            record_seq <= record_seq + 8'd1;
            n_sent++;
        end
    end

    initial begin
        t_sample d;
        int mv_points[6] = '{4419, 4420, 4435, 4436, 8515, 8516};
        int sun_points[6] = '{127, 128, 0, 0, 65535, 0};
        int sys_points[6] = '{0, 0, 127, 128, 0, 65535};
        rst_n = 1'b0;
        smp_if.valid = 1'b0;
        smp_if.data = '0;
        rec_if.ready = 1'b0;

        sample_backlog.push_back(quiet_sample());
        d = '0;
        sample_backlog.push_back(d);
        d = '1;
        sample_backlog.push_back(d);

        // Voltage around the offset and around the top of the code range.
        foreach (mv_points[k]) begin
            d = quiet_sample();
            d.battery_millivolts = 16'(mv_points[k]);
            d.switch_states = (k % 2 == 0) ? 6'b101010 : 6'b010101;
            sample_backlog.push_back(d);
        end
        // Net current clamps; the battery mode walks through the legal and high codes.
        foreach (sun_points[k]) begin
            d = quiet_sample();
            d.solar_current = 16'(sun_points[k]);
            d.system_current = 16'(sys_points[k]);
            d.battery_mode = 3'(k + 1);
            sample_backlog.push_back(d);
        end
        // Rail sums just below, at and past the full-scale points, and at the saturation limit.
        d = quiet_sample();
        d.low_rail_currents = {16'd5499, 16'd0, 16'd0};
        d.high_rail_currents = {16'd4499, 16'd0, 16'd0};
        sample_backlog.push_back(d);
        d.low_rail_currents = {16'd1834, 16'd1833, 16'd1833};
        d.high_rail_currents = {16'd1500, 16'd1500, 16'd1500};
        sample_backlog.push_back(d);
        d.low_rail_currents = {16'd0, 16'd5521, 16'd0};
        d.high_rail_currents = {16'd0, 16'd4517, 16'd0};
        sample_backlog.push_back(d);
        d.low_rail_currents = {16'd0, 16'd0, 16'd5522};
        d.high_rail_currents = {16'd0, 16'd0, 16'd4518};
        sample_backlog.push_back(d);
        // Temperatures: clamps at both ends and truncation of negative averages.
        d = quiet_sample();
        d.board_temps = {4{16'h7fff}};
        d.radio_temp = 16'sd127;
        sample_backlog.push_back(d);
        d.board_temps = {4{16'h8000}};
        d.radio_temp = -16'sd128;
        sample_backlog.push_back(d);
        d.board_temps = {16'sd0, -16'sd2, -16'sd4, 16'sd3};
        d.radio_temp = 16'sd128;
        sample_backlog.push_back(d);
        d.board_temps = {-16'sd2, 16'sd0, -16'sd2, -16'sd3};
        d.radio_temp = -16'sd127;
        sample_backlog.push_back(d);
        d.board_temps = {16'sd200, 16'sd57, 16'sd1, 16'sd254};
        d.radio_temp = 16'sd126;
        sample_backlog.push_back(d);
        d.board_temps = {-16'sd300, -16'sd212, -16'sd1, -16'sd255};
        d.radio_temp = -16'sd126;
        sample_backlog.push_back(d);

        for (int n = 0; n < RANDOM_SAMPLES; n++) begin
            sample_backlog.push_back(random_sample());
        end

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        while (sample_backlog.size() != 0 || smp_if.valid) @(posedge clk);
        while (pending_records.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Sent %0d samples, checked %0d records field by field, %0d mismatches.",
                 n_sent, n_checked, n_errors);
        if (n_errors == 0) begin
            $display("** telemetry_record_packer: PASSED **");
        end else begin
            $display("** telemetry_record_packer: FAILED **");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d records still expected.", pending_records.size());
        $display("** telemetry_record_packer: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

/* telemetry_record_packer.f */
sv/trp_pkg.sv
sv/trp_sample_if.sv
sv/trp_record_if.sv
sv/trp_field_calc.sv
sv/telemetry_record_packer.sv
tb/tb_telemetry_record_packer.sv
